// ===== rtl/leb_pkg.sv =====
// Shared constants and command codes for the line edit buffer engine.
`timescale 1ns / 1ps
package leb_pkg;

    localparam int BUF_SIZE = 128;
    localparam int ADDR_W   = $clog2(BUF_SIZE);

    localparam int OP_W  = 4;
    localparam int CH_W  = 8;
    localparam int OFF_W = 8;
    localparam int IDX_W = 7;
    localparam int LEN_W = 7;

    // Width for comparing the read index with the length.
    localparam int CMP_W = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
    // Signed width for cursor plus offset.
    localparam int SUM_W = ((ADDR_W > OFF_W) ? ADDR_W : OFF_W) + 2;

    localparam logic [OP_W-1:0] OP_INSERT     = 4'd0;
    localparam logic [OP_W-1:0] OP_DELETE     = 4'd1;
    localparam logic [OP_W-1:0] OP_BACKSPACE  = 4'd2;
    localparam logic [OP_W-1:0] OP_MOVE       = 4'd3;
    localparam logic [OP_W-1:0] OP_HOME       = 4'd4;
    localparam logic [OP_W-1:0] OP_END        = 4'd5;
    localparam logic [OP_W-1:0] OP_KILL_END   = 4'd6;
    localparam logic [OP_W-1:0] OP_KILL_START = 4'd7;
    localparam logic [OP_W-1:0] OP_DEL_WORD   = 4'd8;
    localparam logic [OP_W-1:0] OP_CLEAR      = 4'd9;
    localparam logic [OP_W-1:0] OP_READ       = 4'd10;

    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;

endpackage

// ===== rtl/line_edit_buffer_engine.sv =====
// Line edit buffer engine: command sequencer around the line store RAM.
//
// Holds one text line of up to BUF_SIZE-1 characters with a length and a cursor. Each command
// beat on s_ gives exactly one result beat on m_ (status, length, cursor, read character).
// Cursor moves, home, end, kill to end, clear and unknown commands pass through the decode
// and done states before m_valid rises; a read also waits for the registered read data. Insert,
// delete, backspace, kill to start and word delete move characters through the single-port-read
// line store, each character moved by a registered read and then a write; a word delete first
// scans characters, each by a read and then a check. The scan only visits characters before
// the cursor and the copy only those after it.
// s_ready is low while a command is at work;
// a finished result waits in the output register while the next command is taken.
// The insert/overwrite mode bit resets to insert (1) and is written by a cfg_ beat; the user
// must write it only while the block is idle, which the block itself does not enforce.
`timescale 1ns / 1ps
module line_edit_buffer_engine (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [leb_pkg::OP_W-1:0]    s_op,
    input  logic [leb_pkg::CH_W-1:0]    s_ch,
    input  logic signed [leb_pkg::OFF_W-1:0] s_offset,
    input  logic [leb_pkg::IDX_W-1:0]   s_index,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_status,
    output logic [leb_pkg::LEN_W-1:0]   m_line_length,
    output logic [leb_pkg::LEN_W-1:0]   m_cursor_pos,
    output logic [leb_pkg::CH_W-1:0]    m_read_char,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data
);
    import leb_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECODE  = 4'd1;
    localparam logic [3:0] S_SHR_RD  = 4'd2;
    localparam logic [3:0] S_SHR_WR  = 4'd3;
    localparam logic [3:0] S_PUT     = 4'd4;
    localparam logic [3:0] S_CUT_RD  = 4'd5;
    localparam logic [3:0] S_CUT_WR  = 4'd6;
    localparam logic [3:0] S_WD_RD   = 4'd7;
    localparam logic [3:0] S_WD_CHK  = 4'd8;
    localparam logic [3:0] S_RD_WAIT = 4'd9;
    localparam logic [3:0] S_DONE    = 4'd10;

    logic [3:0]              state_reg, state_next;
    logic [ADDR_W-1:0]       count_reg, count_next;
    logic [ADDR_W-1:0]       cursor_reg, cursor_next;
    logic                    ins_mode_reg;
    logic                    m_valid_reg, m_valid_next;

    logic [OP_W-1:0]         op_reg;
    logic [CH_W-1:0]         ch_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic [IDX_W-1:0]        idx_reg;

    logic [ADDR_W-1:0]       ptr_reg, ptr_next;     // shift/scan pointer, cut source
    logic [ADDR_W-1:0]       dst_reg, dst_next;     // cut destination
    logic [ADDR_W-1:0]       lim_reg, lim_next;     // old length during a cut
    logic                    phase_reg, phase_next; // word scan: past the blanks
    logic                    status_reg, status_next;
    logic [CH_W-1:0]         rd_reg, rd_next;

    logic                    m_status_reg;
    logic [LEN_W-1:0]        m_len_reg, m_cur_reg;
    logic [CH_W-1:0]         m_rd_reg;
    logic                    load_out;

    logic                    ram_we;
    logic [ADDR_W-1:0]       ram_waddr, ram_raddr;
    logic [CH_W-1:0]         ram_wdata, ram_rdata;

    logic                    cut_go;
    logic [ADDR_W-1:0]       cut_from, cut_to;
    logic signed [SUM_W-1:0] mv_pos;
    logic                    blank;
    logic [ADDR_W-1:0]       ptr_dec;

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_line_length = m_len_reg;
    assign m_cursor_pos  = m_cur_reg;
    assign m_read_char   = m_rd_reg;

    assign mv_pos = SUM_W'(signed'({1'b0, cursor_reg})) + SUM_W'(off_reg);
    assign blank  = (ram_rdata == CH_SPACE) || (ram_rdata == CH_TAB);
    assign ptr_dec = ptr_reg - ADDR_W'(1);

    leb_ram #(
        .WIDTH (CH_W),
        .DEPTH (BUF_SIZE)
    ) u_line_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        cursor_next  = cursor_reg;
        ptr_next     = ptr_reg;
        dst_next     = dst_reg;
        lim_next     = lim_reg;
        phase_next   = phase_reg;
        status_next  = status_reg;
        rd_next      = rd_reg;
        m_valid_next = m_valid_reg && !m_ready;
        load_out     = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = cursor_reg;
        ram_wdata    = ch_reg;
        ram_raddr    = ptr_dec;
        cut_go       = 1'b0;
        cut_from     = cursor_reg;
        cut_to       = cursor_reg;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                status_next = 1'b0;
                rd_next     = CH_NUL;
                state_next  = S_DONE;
                case (op_reg)
                    OP_INSERT: begin
                        if (count_reg >= ADDR_W'(BUF_SIZE - 1)) begin
                            status_next = 1'b1;
                        end else if (ins_mode_reg && (count_reg > cursor_reg)) begin
                            ptr_next   = count_reg;
                            state_next = S_SHR_RD;
                        end else begin
                            state_next = S_PUT;
                        end
                    end
                    OP_DELETE: begin
                        if (cursor_reg >= count_reg) begin
                            status_next = 1'b1;
                        end else begin
                            cut_go = 1'b1;
                            cut_to = cursor_reg + ADDR_W'(1);
                        end
                    end
                    OP_BACKSPACE: begin
                        if (cursor_reg == '0) begin
                            status_next = 1'b1;
                        end else begin
                            cut_go      = 1'b1;
                            cut_from    = cursor_reg - ADDR_W'(1);
                            cursor_next = cursor_reg - ADDR_W'(1);
                        end
                    end
                    OP_MOVE: begin
                        if (mv_pos[SUM_W-1]) begin
                            cursor_next = '0;
                        end else if (mv_pos > SUM_W'(signed'({1'b0, count_reg}))) begin
                            cursor_next = count_reg;
                        end else begin
                            cursor_next = ADDR_W'(mv_pos);
                        end
                    end
                    OP_HOME: begin
                        cursor_next = '0;
                    end
                    OP_END: begin
                        cursor_next = count_reg;
                    end
                    OP_KILL_END: begin
                        count_next = cursor_reg;
                    end
                    OP_KILL_START: begin
                        if (cursor_reg != '0) begin
                            cut_go      = 1'b1;
                            cut_from    = '0;
                            cursor_next = '0;
                        end
                    end
                    OP_DEL_WORD: begin
                        if (cursor_reg != '0) begin
                            ptr_next   = cursor_reg;
                            phase_next = 1'b0;
                            state_next = S_WD_RD;
                        end
                    end
                    OP_CLEAR: begin
                        count_next  = '0;
                        cursor_next = '0;
                    end
                    OP_READ: begin
                        if (CMP_W'(idx_reg) < CMP_W'(count_reg)) begin
                            ram_raddr  = ADDR_W'(idx_reg);
                            state_next = S_RD_WAIT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SHR_RD: begin
                state_next = S_SHR_WR;
            end
            S_SHR_WR: begin
                ram_we    = 1'b1;
                ram_waddr = ptr_reg;
                ram_wdata = ram_rdata;
                ptr_next  = ptr_dec;
                state_next = (ptr_dec > cursor_reg) ? S_SHR_RD : S_PUT;
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = cursor_reg;
                ram_wdata = ch_reg;
                if (ins_mode_reg || (cursor_reg >= count_reg)) begin
                    count_next = count_reg + ADDR_W'(1);
                end
                cursor_next = cursor_reg + ADDR_W'(1);
                state_next  = S_DONE;
            end
            S_CUT_RD: begin
                ram_raddr  = ptr_reg;
                state_next = S_CUT_WR;
            end
            S_CUT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg;
                ram_wdata = ram_rdata;
                ptr_next  = ptr_reg + ADDR_W'(1);
                dst_next  = dst_reg + ADDR_W'(1);
                state_next = ((ptr_reg + ADDR_W'(1)) < lim_reg) ? S_CUT_RD : S_DONE;
            end
            S_WD_RD: begin
                state_next = S_WD_CHK;
            end
            S_WD_CHK: begin
                // Blanks first, then the word; stop at a blank once past them.
                if ((phase_reg && blank) || (ptr_dec == '0)) begin
                    cut_from = (phase_reg && blank) ? ptr_reg : '0;
                    state_next = S_DONE;
                    if (cut_from != cursor_reg) begin
                        cut_go      = 1'b1;
                        cursor_next = cut_from;
                    end
                end else begin
                    ptr_next   = ptr_dec;
                    phase_next = phase_reg || !blank;
                    state_next = S_WD_RD;
                end
            end
            S_RD_WAIT: begin
                rd_next    = ram_rdata;
                state_next = S_DONE;
            end
            S_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out     = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        // Close the gap [cut_from, cut_to); the length drops at once, copying runs after.
        if (cut_go) begin
            dst_next   = cut_from;
            ptr_next   = cut_to;
            lim_next   = count_reg;
            count_next = count_reg - (cut_to - cut_from);
            state_next = (cut_to < count_reg) ? S_CUT_RD : S_DONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            cursor_reg   <= '0;
            ins_mode_reg <= 1'b1;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            cursor_reg  <= cursor_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                ins_mode_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg  <= s_op;
            ch_reg  <= s_ch;
            off_reg <= s_offset;
            idx_reg <= s_index;
        end
        ptr_reg    <= ptr_next;
        dst_reg    <= dst_next;
        lim_reg    <= lim_next;
        phase_reg  <= phase_next;
        status_reg <= status_next;
        rd_reg     <= rd_next;
        if (load_out) begin
            m_status_reg <= status_reg;
            m_len_reg    <= LEN_W'(count_reg);
            m_cur_reg    <= LEN_W'(cursor_reg);
            m_rd_reg     <= rd_reg;
        end
    end

endmodule

// ===== rtl/leb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module leb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/leb_checker.sv =====
// Port-level checks for the line edit buffer engine, bound to the top level.
`timescale 1ns / 1ps
module leb_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_valid,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic                        m_status,
    input logic [leb_pkg::LEN_W-1:0]   m_line_length,
    input logic [leb_pkg::LEN_W-1:0]   m_cursor_pos,
    input logic [leb_pkg::CH_W-1:0]    m_read_char
);
    import leb_pkg::*;

    // A stalled result beat holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_line_length)
            && $stable(m_cursor_pos) && $stable(m_read_char))
        else $error("result beat changed while stalled");

    // The cursor never passes the end of the line.
    a_cursor_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_cursor_pos <= m_line_length)
        else $error("cursor beyond line length");

    // The line never grows past its capacity.
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> LEN_W'(BUF_SIZE - 1) >= m_line_length)
        else $error("line length beyond capacity");

    // A command beat keeps the block busy for at least the next cycle.
    a_busy_after_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("command taken while previous one at work");

endmodule

bind line_edit_buffer_engine leb_checker u_leb_checker (.*);
